>>> sv/looping_phase_accumulator_defines.svh
// Assertion macros shared by the accumulator RTL.
`ifndef LOOPING_PHASE_ACCUMULATOR_DEFINES_SVH
`define LOOPING_PHASE_ACCUMULATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define LPA_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define LPA_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> sv/lpa_pkg.sv
package lpa_pkg;

   localparam int LEVEL_WIDTH_DEF   = 48;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int TRIG_WIDTH        = 24;
   localparam int CSR_ADDR_WIDTH    = 6;
   localparam int CSR_DATA_WIDTH    = 64;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_WIDTH        = $clog2(QUEUE_DEPTH);

   // register indexes, 8-byte stride
   localparam logic [2:0] REG_START_POS  = 3'd0;
   localparam logic [2:0] REG_END_POS    = 3'd1;
   localparam logic [2:0] REG_LOOP_START = 3'd2;
   localparam logic [2:0] REG_LOOP_END   = 3'd3;
   localparam logic [2:0] REG_SUBSAMPLE  = 3'd4;

   typedef struct packed {
      logic start_edge;
      logic finish_mode;
   } lpa_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_OFFSET,
      ST_RELOAD,
      ST_DECIDE,
      ST_MOD,
      ST_FIX,
      ST_EMIT
   } lpa_state_type;

endpackage

>>> sv/looping_phase_accumulator.sv
// Channel  | Ports              | Payload
// ---------+--------------------+------------------------------------------------
// input    | req_t*  (slave)    | start_trigger, finish_trigger, step_rate
// result   | rsp_t*  (master)   | position
// config   | csr_p*  (APB)      | start, end, loop start, loop end, subsample
//
// Each item runs through the back-end sequencer, which takes the next item only
// once the last is emitted; a start edge that reloads with sub-sample offset adds
// the serial divider and multiplier, and a loop wrap adds the serial modulo unit.
// Synchronous active-high reset; no clearing pass, items accepted right away.
// Input stalls only when the two-entry queue is full; a result waiting in the
// output register does not stop the front end.
module looping_phase_accumulator import lpa_pkg::*; #(
   parameter int LEVEL_WIDTH   = LEVEL_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // tdata: start_trigger, finish_trigger, step_rate, zero pad
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [((2*TRIG_WIDTH+LEVEL_WIDTH+7)/8)*8-1:0] req_tdata,
   // tdata: position, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [((LEVEL_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int RSP_W = ((LEVEL_WIDTH + 7) / 8) * 8;
   localparam int QW    = 2 + 2 * TRIG_WIDTH + LEVEL_WIDTH;

   // configuration
   logic signed [LEVEL_WIDTH-1:0] start_pos, end_pos, loop_start, loop_end;
   logic                          subsample;

   // front end to queue
   logic                          push, full;
   lpa_ctrl_type                  f_ctrl;
   logic [TRIG_WIDTH-1:0]         f_num, f_den;
   logic signed [LEVEL_WIDTH-1:0] f_rate;

   // queue to back end
   logic                          pop, empty;
   logic [QW-1:0]                 q_data;
   lpa_ctrl_type                  b_ctrl;
   logic [TRIG_WIDTH-1:0]         b_num, b_den;
   logic signed [LEVEL_WIDTH-1:0] b_rate;
   logic [LEVEL_WIDTH-1:0]        position;

   lpa_csr #(.LW(LEVEL_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .start_pos   (start_pos),
      .end_pos     (end_pos),
      .loop_start  (loop_start),
      .loop_end    (loop_end),
      .subsample   (subsample)
   );

   // front end: edge detect, finish toggle, divider operands
   lpa_front #(.LW(LEVEL_WIDTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .start_trigger  (req_tdata[TRIG_WIDTH-1:0]),
      .finish_trigger (req_tdata[2*TRIG_WIDTH-1:TRIG_WIDTH]),
      .step_rate      (req_tdata[2*TRIG_WIDTH +: LEVEL_WIDTH]),
      .full           (full),
      .push           (push),
      .ctrl           (f_ctrl),
      .trig_num       (f_num),
      .trig_den       (f_den),
      .rate           (f_rate)
   );

   lpa_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_rate, f_den, f_num, f_ctrl}),
      .pop       (pop),
      .pop_data  (q_data),
      .full      (full),
      .empty     (empty)
   );

   assign b_ctrl = q_data[1:0];
   assign b_num  = q_data[2 +: TRIG_WIDTH];
   assign b_den  = q_data[2 + TRIG_WIDTH +: TRIG_WIDTH];
   assign b_rate = q_data[2 + 2 * TRIG_WIDTH +: LEVEL_WIDTH];

   // back end: reload, loop wrap or clip, accumulate
   lpa_back #(.LW(LEVEL_WIDTH), .FB(FRACTION_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .pop        (pop),
      .ctrl       (b_ctrl),
      .trig_num   (b_num),
      .trig_den   (b_den),
      .rate       (b_rate),
      .start_pos  (start_pos),
      .end_pos    (end_pos),
      .loop_start (loop_start),
      .loop_end   (loop_end),
      .subsample  (subsample),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .position   (position)
   );

   assign rsp_tdata = RSP_W'(position);

endmodule

>>> sv/lpa_csr.sv
module lpa_csr import lpa_pkg::*; #(
   parameter int LW = LEVEL_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic signed [LW-1:0]      start_pos,
   output logic signed [LW-1:0]      end_pos,
   output logic signed [LW-1:0]      loop_start,
   output logic signed [LW-1:0]      loop_end,
   output logic                      subsample
);

   logic signed [LW-1:0] start_ff, end_ff, lstart_ff, lend_ff;
   logic                 sub_ff;
   logic [2:0]           idx;
   logic                 wr;

   assign idx        = csr_paddr[5:3];
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         end_ff    <= '0;
         lstart_ff <= '0;
         lend_ff   <= '0;
         sub_ff    <= 1'b1;
      end else if (wr) begin
         unique case (idx)
            REG_START_POS:  start_ff  <= csr_pwdata[LW-1:0];
            REG_END_POS:    end_ff    <= csr_pwdata[LW-1:0];
            REG_LOOP_START: lstart_ff <= csr_pwdata[LW-1:0];
            REG_LOOP_END:   lend_ff   <= csr_pwdata[LW-1:0];
            REG_SUBSAMPLE:  sub_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_START_POS:  csr_prdata = CSR_DATA_WIDTH'(start_ff);
         REG_END_POS:    csr_prdata = CSR_DATA_WIDTH'(end_ff);
         REG_LOOP_START: csr_prdata = CSR_DATA_WIDTH'(lstart_ff);
         REG_LOOP_END:   csr_prdata = CSR_DATA_WIDTH'(lend_ff);
         REG_SUBSAMPLE:  csr_prdata = CSR_DATA_WIDTH'(sub_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign start_pos  = start_ff;
   assign end_pos    = end_ff;
   assign loop_start = lstart_ff;
   assign loop_end   = lend_ff;
   assign subsample  = sub_ff;

endmodule

>>> sv/lpa_front.sv
module lpa_front import lpa_pkg::*; #(
   parameter int LW = LEVEL_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic signed [TRIG_WIDTH-1:0] start_trigger,
   input  logic signed [TRIG_WIDTH-1:0] finish_trigger,
   input  logic signed [LW-1:0]        step_rate,
   input  logic                        full,
   output logic                        push,
   output lpa_ctrl_type                ctrl,
   output logic [TRIG_WIDTH-1:0]       trig_num,
   output logic [TRIG_WIDTH-1:0]       trig_den,
   output logic signed [LW-1:0]        rate
);

   logic signed [TRIG_WIDTH-1:0] last_start_ff, last_finish_ff;
   logic                         finish_ff, finish_in;
   logic                         start_edge, finish_edge;
   logic signed [TRIG_WIDTH:0]   neg_last, diff;

   assign req_tready  = ~full;
   assign push        = req_tvalid & ~full;

   // rising edge: previous <= 0, current > 0
   assign start_edge  = (last_start_ff <= 0) && (start_trigger > 0);
   assign finish_edge = (last_finish_ff <= 0) && (finish_trigger > 0);
   assign finish_in   = finish_ff ^ finish_edge;

   // -prev fits in TRIG_WIDTH unsigned bits, as does cur - prev on an edge
   assign neg_last = -{last_start_ff[TRIG_WIDTH-1], last_start_ff};
   assign diff     = {start_trigger[TRIG_WIDTH-1], start_trigger}
                     - {last_start_ff[TRIG_WIDTH-1], last_start_ff};

   assign ctrl.start_edge  = start_edge;
   assign ctrl.finish_mode = finish_in;
   assign trig_num         = neg_last[TRIG_WIDTH-1:0];
   assign trig_den         = diff[TRIG_WIDTH-1:0];
   assign rate             = step_rate;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_start_ff  <= '0;
         last_finish_ff <= '0;
         finish_ff      <= 1'b0;
      end else if (push) begin
         last_start_ff  <= start_trigger;
         last_finish_ff <= finish_trigger;
         finish_ff      <= finish_in;
      end
   end

endmodule

>>> sv/lpa_queue.sv
`include "looping_phase_accumulator_defines.svh"

module lpa_queue import lpa_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]      slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_WIDTH:0]   count_ff;

   assign full     = (count_ff == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   `LPA_CHECK(a_fill_bound, clock, reset, count_ff <= (QPTR_WIDTH+1)'(QUEUE_DEPTH), "queue overfilled")
   `LPA_NEVER(a_pop_empty, clock, reset, pop && empty, "pop from empty queue")

endmodule

>>> sv/lpa_back.sv
`include "looping_phase_accumulator_defines.svh"

module lpa_back import lpa_pkg::*; #(
   parameter int LW = LEVEL_WIDTH_DEF,
   parameter int FB = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   output logic                  pop,
   input  lpa_ctrl_type          ctrl,
   input  logic [TRIG_WIDTH-1:0] trig_num,
   input  logic [TRIG_WIDTH-1:0] trig_den,
   input  logic signed [LW-1:0]  rate,
   input  logic signed [LW-1:0]  start_pos,
   input  logic signed [LW-1:0]  end_pos,
   input  logic signed [LW-1:0]  loop_start,
   input  logic signed [LW-1:0]  loop_end,
   input  logic                  subsample,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [LW-1:0]         position
);

   localparam int CW = $clog2((LW > FB) ? LW : FB);
   localparam int PW = LW + FB + 1;
   localparam int RW = TRIG_WIDTH + 1;
   localparam logic signed [LW-1:0] LVL_MAX = {1'b0, {(LW-1){1'b1}}};
   localparam logic signed [LW-1:0] LVL_MIN = {1'b1, {(LW-1){1'b0}}};

   function automatic logic signed [LW-1:0] sat_add(input logic signed [LW-1:0] a,
                                                    input logic signed [LW-1:0] b);
      logic [LW:0] s;
      s = {a[LW-1], a} + {b[LW-1], b};
      if (s[LW] != s[LW-1]) sat_add = s[LW] ? LVL_MIN : LVL_MAX;
      else sat_add = s[LW-1:0];
   endfunction

   lpa_state_type        state_ff, state_in;
   lpa_ctrl_type         ctrl_ff, ctrl_in;
   logic signed [LW-1:0] rate_ff, rate_in;
   logic [TRIG_WIDTH-1:0] den_ff, den_in;
   logic [RW-1:0]        drem_ff, drem_in;
   logic [FB-1:0]        quo_ff, quo_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [LW-1:0] work_ff, work_in;
   logic signed [LW-1:0] level_ff, level_in;
   logic                 looping_ff, looping_in;
   logic [LW-1:0]        dist_ff, dist_in;
   logic [LW-1:0]        modulus_ff, modulus_in;
   logic [LW:0]          mrem_ff, mrem_in;
   logic                 dir_ff, dir_in, below_ff, below_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [LW-1:0]        out_ff, out_in;

   logic [RW-1:0]        dtrial;
   logic [LW:0]          mtrial;
   logic                 loop_now;
   logic signed [LW-1:0] clip_hi;
   logic [LW-1:0]        m;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         looping_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         looping_ff   <= looping_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff    <= ctrl_in;
      rate_ff    <= rate_in;
      den_ff     <= den_in;
      drem_ff    <= drem_in;
      quo_ff     <= quo_in;
      prod_ff    <= prod_in;
      work_ff    <= work_in;
      dist_ff    <= dist_in;
      modulus_ff <= modulus_in;
      mrem_ff    <= mrem_in;
      dir_ff     <= dir_in;
      below_ff   <= below_in;
      cnt_ff     <= cnt_in;
      out_ff     <= out_in;
   end

   always_comb begin
      state_in     = state_ff;
      ctrl_in      = ctrl_ff;
      rate_in      = rate_ff;
      den_in       = den_ff;
      drem_in      = drem_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      work_in      = work_ff;
      level_in     = level_ff;
      looping_in   = looping_ff;
      dist_in      = dist_ff;
      modulus_in   = modulus_ff;
      mrem_in      = mrem_ff;
      dir_in       = dir_ff;
      below_in     = below_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      pop          = 1'b0;
      dtrial       = {drem_ff[RW-2:0], 1'b0};
      mtrial       = {mrem_ff[LW-1:0], dist_ff[LW-1]};
      loop_now     = looping_ff | (work_ff >= loop_start);
      clip_hi      = (work_ff > end_pos) ? end_pos : work_ff;
      m            = mrem_ff[LW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               ctrl_in = ctrl;
               rate_in = rate;
               den_in  = trig_den;
               drem_in = RW'(trig_num);
               quo_in  = '0;
               cnt_in  = CW'(FB - 1);
               if (ctrl.start_edge && subsample) begin
                  state_in = ST_DIV;
               end else begin
                  work_in  = ctrl.start_edge ? start_pos : level_ff;
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DIV: begin
            // trigger fraction, one quotient bit per cycle
            if (dtrial >= {1'b0, den_ff}) begin
               drem_in = dtrial - {1'b0, den_ff};
               quo_in  = {quo_ff[FB-2:0], 1'b1};
            end else begin
               drem_in = dtrial;
               quo_in  = {quo_ff[FB-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               cnt_in   = CW'(FB - 1);
               prod_in  = '0;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MUL: begin
            // shift-add, fraction MSB first
            prod_in = (prod_ff <<< 1) + (quo_ff[FB-1] ? PW'(rate_ff) : PW'(0));
            quo_in  = {quo_ff[FB-2:0], 1'b0};
            if (cnt_ff == '0) state_in = ST_OFFSET;
            else cnt_in = cnt_ff - 1'b1;
         end
         ST_OFFSET: begin
            work_in  = sat_add(rate_ff, prod_ff[FB +: LW]);
            state_in = ST_RELOAD;
         end
         ST_RELOAD: begin
            work_in  = sat_add(start_pos, work_ff);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!ctrl_ff.finish_mode) begin
               looping_in = loop_now;
               if (!loop_now) begin
                  state_in = ST_EMIT;
               end else if (loop_start == loop_end) begin
                  work_in  = loop_start;
                  state_in = ST_EMIT;
               end else begin
                  dir_in     = loop_start < loop_end;
                  below_in   = (loop_start < loop_end) ? (work_ff < loop_start)
                                                       : (work_ff > loop_start);
                  dist_in    = (work_ff < loop_start) ? LW'(loop_start - work_ff)
                                                      : LW'(work_ff - loop_start);
                  modulus_in = (loop_start < loop_end) ? LW'(loop_end - loop_start)
                                                       : LW'(loop_start - loop_end);
                  mrem_in    = '0;
                  cnt_in     = CW'(LW - 1);
                  state_in   = ST_MOD;
               end
            end else begin
               work_in  = (clip_hi < start_pos) ? start_pos : clip_hi;
               state_in = ST_EMIT;
            end
         end
         ST_MOD: begin
            // restoring remainder, one distance bit per cycle
            if (mtrial >= {1'b0, modulus_ff}) mrem_in = mtrial - {1'b0, modulus_ff};
            else mrem_in = mtrial;
            dist_in = {dist_ff[LW-2:0], 1'b0};
            if (cnt_ff == '0) state_in = ST_FIX;
            else cnt_in = cnt_ff - 1'b1;
         end
         ST_FIX: begin
            if (!below_ff) begin
               work_in = dir_ff ? (loop_start + m) : (loop_start - m);
            end else if (m == '0) begin
               work_in = loop_start;
            end else begin
               work_in = dir_ff ? (loop_end - m) : (loop_end + m);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_in       = work_ff;
               level_in     = sat_add(work_ff, rate_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign position   = out_ff;

   `LPA_CHECK(a_div_runs, clock, reset, (state_ff == ST_DIV && cnt_ff != '0) |=> state_ff == ST_DIV, "divide cut short")
   `LPA_CHECK(a_emit_lands, clock, reset, (state_ff == ST_EMIT && (!out_valid_ff || rsp_tready)) |=> (out_valid_ff && state_ff == ST_IDLE), "result not registered")

endmodule
